[design/lpfd_pkg.sv]
// Package for the length-prefixed frame deframer.
// Holds the header constants, status codes and the structs passed between stages.
// No dependencies.
package lpfd_pkg;

  localparam logic [31:0] DEFAULT_MAX_PAYLOAD = 32'd65536;
  localparam int          HEADER_BYTES        = 5;
  // Bytes of the little-endian length field; the kind byte follows them.
  localparam int          LEN_BYTES           = HEADER_BYTES - 1;

  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    logic [1:0] item_status;
    logic [7:0] payload_byte;
    logic [7:0] frame_kind;
    logic       last_of_frame;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } core_out_t;

endpackage

[design/lpfd_byte_if.sv]
// Byte stream channel for the deframer input.
// Depends on nothing.
interface lpfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

[design/lpfd_result_if.sv]
// Result channel of the deframer: status, data byte, kind and last mark.
// Depends on nothing.
interface lpfd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_status;
  logic [7:0] payload_byte;
  logic [7:0] frame_kind;
  logic       last_of_frame;

  modport source (output valid, output item_status, output payload_byte,
                  output frame_kind, output last_of_frame, input ready);
  modport sink   (input valid, input item_status, input payload_byte,
                  input frame_kind, input last_of_frame, output ready);
endinterface

[design/lpfd_cfg_if.sv]
// Configuration write channel carrying the maximum payload register.
// Depends on nothing.
interface lpfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload_cap;

  modport source (output valid, output payload_cap, input ready);
  modport sink   (input valid, input payload_cap, output ready);
endinterface

[design/lpfd_in_reg.sv]
// Input register of the deframer: holds one accepted byte until the core takes it.
// Depends on lpfd_pkg and lpfd_byte_if.
module lpfd_in_reg (
  input  logic            clk,
  input  logic            rst,
  lpfd_byte_if.sink       stream,
  input  logic            advance,
  output lpfd_pkg::stage_t stage
);
  import lpfd_pkg::*;

  logic       valid;
  logic [7:0] data;

  assign stream.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (stream.ready) begin
      valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      data <= stream.in_byte;
    end
  end

  assign stage.valid = valid;
  assign stage.data  = data;
endmodule

[design/lpfd_core.sv]
// Deframer core: header assembly, length check and payload count.
// Depends on lpfd_pkg.
module lpfd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          in_data,
  input  logic [31:0]         payload_cap,
  output lpfd_pkg::core_out_t out
);
  import lpfd_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_STUCK} phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [31:0] length_word, length_word_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [7:0]  kind_held, kind_held_next;
  logic [31:0] limit;

  assign limit = (payload_cap != 32'd0) ? payload_cap : DEFAULT_MAX_PAYLOAD;

  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    length_word_next  = length_word;
    bytes_left_next   = bytes_left;
    kind_held_next    = kind_held;
    out               = '0;
    unique case (phase)
      PH_HEADER: begin
        if (header_index != 3'(LEN_BYTES)) begin
          case (header_index[1:0])
            2'd0:    length_word_next[7:0]   = in_data;
            2'd1:    length_word_next[15:8]  = in_data;
            2'd2:    length_word_next[23:16] = in_data;
            default: length_word_next[31:24] = in_data;
          endcase
          header_index_next = header_index + 3'd1;
        end else begin
          kind_held_next       = in_data;
          header_index_next    = 3'd0;
          length_word_next     = 32'd0;
          out.res.frame_kind   = in_data;
          if (length_word > limit) begin
            phase_next          = PH_STUCK;
            out.valid           = 1'b1;
            out.res.item_status = ST_OVERSIZE;
          end else if (length_word == 32'd0) begin
            out.valid             = 1'b1;
            out.res.item_status   = ST_EMPTY;
            out.res.last_of_frame = 1'b1;
          end else begin
            bytes_left_next = length_word;
            phase_next      = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        out.valid            = 1'b1;
        out.res.item_status  = ST_DATA;
        out.res.payload_byte = in_data;
        out.res.frame_kind   = kind_held;
        if (bytes_left <= 32'd1) begin
          out.res.last_of_frame = 1'b1;
          bytes_left_next       = 32'd0;
          phase_next            = PH_HEADER;
        end else begin
          bytes_left_next = bytes_left - 32'd1;
        end
      end
      // The stuck phase and the unused code both drop every byte.
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_index <= 3'd0;
      length_word  <= 32'd0;
      bytes_left   <= 32'd0;
      kind_held    <= 8'd0;
    end else if (fire) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      length_word  <= length_word_next;
      bytes_left   <= bytes_left_next;
      kind_held    <= kind_held_next;
    end
  end
endmodule

[design/lpfd_out_reg.sv]
// Result register of the deframer: holds one result until the consumer takes it.
// Depends on lpfd_pkg and lpfd_result_if.
module lpfd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  lpfd_pkg::core_out_t core_out,
  output logic                free,
  lpfd_result_if.source       result
);
  import lpfd_pkg::*;

  logic    valid;
  result_t res;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fire) begin
      valid <= core_out.valid;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && core_out.valid) begin
      res <= core_out.res;
    end
  end

  assign result.valid         = valid;
  assign result.item_status   = res.item_status;
  assign result.payload_byte  = res.payload_byte;
  assign result.frame_kind    = res.frame_kind;
  assign result.last_of_frame = res.last_of_frame;
endmodule

[design/length_prefixed_frame_deframer_unit.sv]
// Length-prefixed frame deframer, top level.
// Throughput: one byte per clock cycle while the result register is free, set by the single
// length compare and count step. A byte's result goes from the core into the result register.
// Reset (rst, synchronous, active high) empties both registers, returns to the header phase
// and sets payload_cap to zero, which selects the default maximum of 65536 bytes.
// Depends on lpfd_pkg, the three channel interfaces, lpfd_in_reg, lpfd_core and lpfd_out_reg.
module length_prefixed_frame_deframer_unit (
  input  logic          clk,
  input  logic          rst,
  lpfd_byte_if.sink     stream,
  lpfd_cfg_if.sink      cfg,
  lpfd_result_if.source result
);
  import lpfd_pkg::*;

  // The maximum payload register. The user writes it only while the block is idle, which
  // is not enforced. The port is always ready; the value is sampled when a header completes.
  logic [31:0] payload_cap;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_cap <= 32'd0;
    end else if (cfg.valid) begin
      payload_cap <= cfg.payload_cap;
    end
  end

  stage_t    stage;
  core_out_t core_out;
  logic      out_free;
  logic      fire;

  // The core processes the held byte whenever the result register can take
  // whatever it produces: it is empty, or its result is being transferred now.
  // Bytes that give no result still wait for that, which keeps the order simple.
  assign fire = stage.valid && out_free;

  lpfd_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .advance (fire),
    .stage   (stage)
  );

  lpfd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .in_data     (stage.data),
    .payload_cap (payload_cap),
    .out         (core_out)
  );

  lpfd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .core_out (core_out),
    .free     (out_free),
    .result   (result)
  );
endmodule

[dv/length_prefixed_frame_deframer_unit_tb.sv]
// Self-checking testbench for the length-prefixed frame deframer unit.
// A short table of directed bytes and writes is split around random framed traffic; each
// result is checked by a byte-level predictor. Depends on lpfd_pkg, three channels and the unit.
module length_prefixed_frame_deframer_unit_tb;
  import lpfd_pkg::*;

  // Cycles the pipeline may still be busy on a byte that produces no result.
  localparam int PIPE_SETTLE = 4;

  typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_STUCK} deframe_phase_t;
  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  // One row of the directed table: a stream byte or a register write. Where typed is set,
  // res is the result written out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    row_op_t     op;
    logic [31:0] value;
    logic        typed;
    result_t     res;
  } row_t;

  localparam result_t NO_RES   = '0;
  localparam int      PRE_ROWS = 26;
  localparam int      N_ROWS   = 34;

  row_t step_rows [0:N_ROWS-1] = '{
    // Right after reset the default maximum applies: an empty frame with kind 0xFF.
    '{ROW_BYTE, 32'h00, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'hFF, 1'b1, '{ST_EMPTY, 8'h00, 8'hFF, 1'b1}},
    // One-byte frame, kind 0x00, payload 0xFF: the single byte is also the last.
    '{ROW_BYTE, 32'h01, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'hFF, 1'b1, '{ST_DATA, 8'hFF, 8'h00, 1'b1}},
    // A small maximum, then a frame exactly at that maximum.
    '{ROW_CFG,  32'h3,  1'b0, NO_RES},
    '{ROW_BYTE, 32'h03, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'hA5, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b0, NO_RES}, '{ROW_BYTE, 32'h80, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h7F, 1'b0, NO_RES},
    // Largest maximum, then another empty frame.
    '{ROW_CFG,  32'hFFFF_FFFF, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h00, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h80, 1'b1, '{ST_EMPTY, 8'h00, 8'h80, 1'b1}},
    // Closing rows, run after the random traffic since the error sticks until reset:
    // back to the default maximum, then a length one above it.
    '{ROW_CFG,  32'h0,  1'b0, NO_RES},
    '{ROW_BYTE, 32'h01, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h01, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
    '{ROW_BYTE, 32'h3C, 1'b1, '{ST_OVERSIZE, 8'h00, 8'h3C, 1'b0}},
    // Everything after the error is dropped.
    '{ROW_BYTE, 32'hFF, 1'b0, NO_RES}, '{ROW_BYTE, 32'h00, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        src_valid = 1'b0;
  logic [7:0]  src_byte  = 8'h00;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = 32'h0;
  logic        sink_ready = 1'b0;
  int unsigned sink_hold  = 0;
  bit          sink_calm  = 1'b0;
  bit          src_calm   = 1'b0;

  lpfd_byte_if   stream_if ();
  lpfd_cfg_if    cfg_if ();
  lpfd_result_if res_if ();

  assign stream_if.valid   = src_valid;
  assign stream_if.in_byte = src_byte;
  assign cfg_if.valid       = cfg_valid;
  assign cfg_if.payload_cap = cfg_data;
  assign res_if.ready       = sink_ready;

  length_prefixed_frame_deframer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .cfg    (cfg_if),
    .result (res_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state, mirroring the block's own registers.
  deframe_phase_t ph       = PH_HEADER;
  int unsigned    hdr_idx  = 0;
  logic [31:0]    len_acc  = 32'h0;
  logic [31:0]    left     = 32'h0;
  logic [7:0]     kind_cur = 8'h00;
  logic [31:0]    cfg_max  = 32'h0;

  result_t     due_results [$];
  int unsigned err_count  = 0;
  int unsigned bytes_sent = 0;

  task automatic flag_error(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Advances the predictor by one stream byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [31:0] limit;
    logic        last;
    r = '0;
    case (ph)
      PH_HEADER: begin
        if (hdr_idx < LEN_BYTES) begin
          len_acc = len_acc | ({24'h0, b} << (8 * hdr_idx));
          hdr_idx++;
          return 1'b0;
        end
        kind_cur = b;
        hdr_idx  = 0;
        limit    = (cfg_max != 32'h0) ? cfg_max : DEFAULT_MAX_PAYLOAD;
        if (len_acc > limit) begin
          ph      = PH_STUCK;
          len_acc = 32'h0;
          r       = '{ST_OVERSIZE, 8'h00, kind_cur, 1'b0};
          return 1'b1;
        end
        if (len_acc == 32'h0) begin
          r = '{ST_EMPTY, 8'h00, kind_cur, 1'b1};
          return 1'b1;
        end
        left    = len_acc;
        len_acc = 32'h0;
        ph      = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        last = (left <= 32'd1);
        r    = '{ST_DATA, b, kind_cur, last};
        if (last) begin
          left = 32'h0;
          ph   = PH_HEADER;
        end else begin
          left--;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Mostly back to back, sometimes a few idle cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (src_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [31:0] pick_max();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return DEFAULT_MAX_PAYLOAD;
      4: return 32'd65535;
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  // Random backpressure on the result side.
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (sink_calm || $urandom_range(0, 2) != 0) begin
      sink_ready <= 1'b1;
      sink_hold  <= $urandom_range(0, 5);
    end else begin
      sink_ready <= 1'b0;
      sink_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end
  end

  // Compare every result transfer with the oldest expected one.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        flag_error("result transfer with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (res_if.item_status !== want.item_status)
          flag_error($sformatf("item_status %0d, expected %0d",
                               res_if.item_status, want.item_status));
        if (res_if.payload_byte !== want.payload_byte)
          flag_error($sformatf("payload_byte %02h, expected %02h",
                               res_if.payload_byte, want.payload_byte));
        if (res_if.frame_kind !== want.frame_kind)
          flag_error($sformatf("frame_kind %02h, expected %02h",
                               res_if.frame_kind, want.frame_kind));
        if (res_if.last_of_frame !== want.last_of_frame)
          flag_error($sformatf("last_of_frame %0d, expected %0d",
                               res_if.last_of_frame, want.last_of_frame));
      end
    end
  end

  // Offers one byte, waits for its transfer and records what it should produce.
  // Valid is left high on return so that back-to-back bytes need no extra edge.
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_res);
    int unsigned gap;
    result_t     got;
    bit          has;
    gap = pick_gap();
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_byte  <= b;
    do @(posedge clk); while (stream_if.ready !== 1'b1);
    has = deframe_byte(b, got);
    if (typed) due_results.push_back(typed_res);
    else if (has) due_results.push_back(got);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // Register writes happen only with the stream idle and the pipeline settled.
  task automatic write_max(input logic [31:0] v);
    wait_drained();
    repeat (PIPE_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_valid <= 1'b0;
    cfg_max = v;
  endtask

  task automatic walk_rows(input int lo, input int hi);
    for (int i = lo; i < hi; i++) begin
      if (step_rows[i].op == ROW_CFG) write_max(step_rows[i].value);
      else send_byte(step_rows[i].value[7:0], step_rows[i].typed, step_rows[i].res);
    end
  endtask

  // One well-formed frame with a length the current maximum accepts. Sometimes the maximum
  // is rewritten first, occasionally in the middle of the header.
  task automatic send_random_frame();
    int unsigned cfg_at;
    int unsigned cap;
    int unsigned short_cap;
    int unsigned r;
    logic [31:0] new_max;
    logic [31:0] limit;
    logic [31:0] len;
    logic [7:0]  kind;
    cfg_at  = HEADER_BYTES;
    new_max = 32'h0;
    if ($urandom_range(0, 19) == 0) begin
      cfg_at  = $urandom_range(0, HEADER_BYTES - 1);
      new_max = pick_max();
    end
    limit = (cfg_at < HEADER_BYTES) ? new_max : cfg_max;
    if (limit == 32'h0) limit = DEFAULT_MAX_PAYLOAD;
    cap       = (limit < 32'd200) ? limit : 200;
    short_cap = (cap < 24) ? cap : 24;
    r = $urandom_range(0, 99);
    if (r < 12)      len = 32'h0;
    else if (r < 25) len = 32'h1;
    else if (r < 32) len = cap;
    else if (r < 36) len = $urandom_range(0, cap);
    else             len = $urandom_range(0, short_cap);
    kind = $urandom_range(0, 255);
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (i == cfg_at) write_max(new_max);
      send_byte((i < LEN_BYTES) ? len[8*i +: 8] : kind, 1'b0, NO_RES);
    end
    for (int unsigned n = 0; n < len; n++)
      send_byte($urandom_range(0, 255), 1'b0, NO_RES);
    // Hold the stream off until the results catch up now and then.
    if ($urandom_range(0, 29) == 0) wait_drained();
    if ($urandom_range(0, 7) == 0) src_calm = ~src_calm;
    if ($urandom_range(0, 7) == 0) sink_calm <= ~sink_calm;
  endtask

  initial begin : run_stimulus
    int unsigned random_end;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    walk_rows(0, PRE_ROWS);
    random_end = bytes_sent + 1000;
    while (bytes_sent < random_end) send_random_frame();
    walk_rows(PRE_ROWS, N_ROWS);
    repeat (12) send_byte($urandom_range(0, 255), 1'b0, NO_RES);
    wait_drained();
    repeat (PIPE_SETTLE * 2) @(posedge clk);
    if (err_count == 0) begin
      $display("length_prefixed_frame_deframer_unit_tb: clean");
    end else begin
      $display("length_prefixed_frame_deframer_unit_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("length_prefixed_frame_deframer_unit_tb: errors");
    $finish;
  end

endmodule
